// File: src/p16c_pkg.sv
package p16c_pkg;

    localparam logic [15:0] NAR_PATTERN = 16'h8000;
    localparam logic [15:0] POSIT_ONE   = 16'h4000;
    localparam logic [15:0] POSIT_ZERO  = 16'h0000;
    localparam logic [27:0] HALF_VALUE  = 28'h8000000;
    localparam logic [26:0] TINY_LIMIT  = 27'h00E6001;
    localparam logic [24:0] ALMOST_ONE  = 25'h1FFFFFF;

    localparam logic [14:0] COEF_A = 15'd28875;
    localparam logic [18:0] COEF_B = 19'd349194;
    localparam logic [22:0] COEF_C = 23'd4255560;
    localparam logic [24:0] COEF_D = 25'd20698014;
    localparam logic [24:0] COEF_E = 25'd33554428;

    localparam int STAGES = 12;

    typedef struct packed {
        logic        nar;
        logic        zero;
        logic [12:0] mant;
        logic [5:0]  shamt;
    } dec_t;

    typedef struct packed {
        logic        sign;
        logic        special;
        logic [15:0] spec_val;
        logic        tiny;
    } side_t;

endpackage

// File: src/p16c_decode.sv
module p16c_decode (
    input  logic [15:0]    posit_in,
    output p16c_pkg::dec_t dec
);
    import p16c_pkg::*;

    logic [15:0] mag;
    logic        pol;
    logic [3:0]  run;
    logic [14:0] aligned;
    logic [6:0]  amt;

    always_comb
    begin
        mag = posit_in[15] ? (16'h0000 - posit_in) : posit_in;
        pol = mag[14];
        run = 4'd14;
        for (int i = 0; i < 14; i++)
        begin
            if (mag[i] != pol)
            begin
                run = 4'(13 - i);
            end
        end
        aligned = mag[14:0] << run;
        if (pol)
        begin
            amt = 7'd28 + {2'b00, run, 1'b0} + {6'd0, aligned[12]};
        end
        else
        begin
            amt = 7'd26 - {2'b00, run, 1'b0} + {6'd0, aligned[12]};
        end
        dec.nar   = (posit_in == NAR_PATTERN);
        dec.zero  = (posit_in == POSIT_ZERO);
        dec.mant  = {1'b1, aligned[11:0]};
        dec.shamt = amt[5:0];
    end

endmodule

// File: src/posit16_cospi_fixed_point_core.sv
// Channel | Signals                      | Direction | Transfer when
// in      | in_valid, in_stall, posit_in  | to core   | in_valid && !in_stall
// out     | out_valid, out_stall, posit_out| from core | out_valid && !out_stall
//
// Twelve register stages; one item enters per cycle while in_stall is low.
// The multiplier chain of the Horner polynomial sets the depth.
// rst_n clears the stage valid bits only; no other state.
// A stall holds only as far back as the first empty stage; bubbles drain.
module posit16_cospi_fixed_point_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] posit_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] posit_out
);
    import p16c_pkg::*;

    logic [STAGES:1] vld_reg;
    logic [STAGES:1] en;

    dec_t        dec_next;
    dec_t        dec1_reg;
    logic        nar2_reg;
    logic [28:0] fx2_reg;
    logic [28:0] fx_next;
    logic [69:0] wide;

    logic [1:0]  quad;
    logic [26:0] rem;
    logic [27:0] mir;
    logic [26:0] red;
    side_t       side_next;
    side_t       side_reg [3:11];
    logic [15:0] sq0_3_reg;

    logic [31:0] sq_prod;
    logic [23:0] sq4_reg, sq5_reg, sq6_reg, sq7_reg;
    logic [38:0] prod5;
    logic [13:0] t5_reg;
    logic [18:0] acc1;
    logic [42:0] prod6;
    logic [18:0] m6_reg;
    logic [22:0] acc2;
    logic [46:0] prod7;
    logic [22:0] m7_reg;
    logic [24:0] acc3;
    logic [48:0] prod8;
    logic [25:0] m8_reg;

    logic [25:0] diff;
    logic [24:0] v_next;
    logic [4:0]  lz_next;
    logic [24:0] v9_reg;
    logic [4:0]  lz9_reg;

    logic [24:0] vn;
    logic        odd;
    logic [4:0]  sc;
    logic [4:0]  sh_next;
    logic [25:0] vx10_reg;
    logic [4:0]  sh10_reg;

    logic [4:0]  rpos;
    logic [25:0] mask;
    logic        up;
    logic [26:0] vr_next;
    logic [26:0] vr11_reg;
    logic [4:0]  sh11_reg;

    logic [26:0] q;
    logic [15:0] out_next;
    logic [15:0] posit_out_reg;

    always_comb
    begin
        en[STAGES] = !vld_reg[STAGES] || !out_stall;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            en[i] = !vld_reg[i] || en[i + 1];
        end
    end

    assign in_stall  = !en[1];
    assign out_valid = vld_reg[STAGES];
    assign posit_out = posit_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= in_valid;
            end
            for (int i = 2; i <= STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i - 1];
                end
            end
        end
    end

    p16c_decode u_decode (
        .posit_in (posit_in),
        .dec      (dec_next)
    );

    always_comb
    begin
        wide    = {57'd0, dec1_reg.mant} << dec1_reg.shamt;
        fx_next = dec1_reg.zero ? 29'd0 : wide[40:12];
    end

    always_comb
    begin
        quad = fx2_reg[28:27];
        rem  = fx2_reg[26:0];
        mir  = HALF_VALUE - {1'b0, rem};
        red  = quad[0] ? mir[26:0] : rem;
        side_next.sign     = quad[1] ^ quad[0];
        side_next.special  = nar2_reg || (rem == 27'd0);
        if (nar2_reg)
        begin
            side_next.spec_val = NAR_PATTERN;
        end
        else if (quad[0])
        begin
            side_next.spec_val = POSIT_ZERO;
        end
        else
        begin
            side_next.spec_val = {quad[1] ^ quad[0], POSIT_ONE[14:0]};
        end
        side_next.tiny = (red < TINY_LIMIT);
    end

    assign sq_prod = {16'd0, sq0_3_reg} * {16'd0, sq0_3_reg};
    assign prod5   = {15'd0, sq4_reg} * {24'd0, COEF_A};
    assign acc1    = COEF_B - {5'd0, t5_reg};
    assign prod6   = {19'd0, sq5_reg} * {24'd0, acc1};
    assign acc2    = COEF_C - {4'd0, m6_reg};
    assign prod7   = {23'd0, sq6_reg} * {24'd0, acc2};
    assign acc3    = COEF_D - {2'd0, m7_reg};
    assign prod8   = {25'd0, sq7_reg} * {24'd0, acc3};

    always_comb
    begin
        diff    = {1'b0, COEF_E} - m8_reg;
        v_next  = side_reg[8].tiny ? ALMOST_ONE : diff[24:0];
        lz_next = 5'd25;
        for (int i = 0; i < 25; i++)
        begin
            if (v_next[i])
            begin
                lz_next = 5'(24 - i);
            end
        end
    end

    always_comb
    begin
        vn  = v9_reg << lz9_reg;
        odd = !lz9_reg[0];
        sc  = lz9_reg + 5'd1;
        if (!odd)
        begin
            vn[24] = 1'b0;
        end
        sh_next = (sc >> 1) + 5'd12 - {4'd0, !odd};
    end

    always_comb
    begin
        rpos    = sh10_reg - 5'd1;
        mask    = (26'd1 << rpos) - 26'd1;
        up      = vx10_reg[rpos] && ((|(vx10_reg & mask)) || vx10_reg[sh10_reg]);
        vr_next = {1'b0, vx10_reg} + (up ? (27'd1 << rpos) : 27'd0);
    end

    always_comb
    begin
        q = vr11_reg >> sh11_reg;
        if (side_reg[11].special)
        begin
            out_next = side_reg[11].spec_val;
        end
        else if (side_reg[11].sign)
        begin
            out_next = 16'h0000 - q[15:0];
        end
        else
        begin
            out_next = q[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dec1_reg <= dec_next;
        end
        if (en[2])
        begin
            fx2_reg  <= fx_next;
            nar2_reg <= dec1_reg.nar;
        end
        if (en[3])
        begin
            side_reg[3] <= side_next;
            sq0_3_reg   <= red[26:11];
        end
        if (en[4])
        begin
            side_reg[4] <= side_reg[3];
            sq4_reg     <= sq_prod[31:8];
        end
        if (en[5])
        begin
            side_reg[5] <= side_reg[4];
            sq5_reg     <= sq4_reg;
            t5_reg      <= prod5[38:25];
        end
        if (en[6])
        begin
            side_reg[6] <= side_reg[5];
            sq6_reg     <= sq5_reg;
            m6_reg      <= prod6[42:24];
        end
        if (en[7])
        begin
            side_reg[7] <= side_reg[6];
            sq7_reg     <= sq6_reg;
            m7_reg      <= prod7[46:24];
        end
        if (en[8])
        begin
            side_reg[8] <= side_reg[7];
            m8_reg      <= prod8[48:23];
        end
        if (en[9])
        begin
            side_reg[9] <= side_reg[8];
            v9_reg      <= v_next;
            lz9_reg     <= lz_next;
        end
        if (en[10])
        begin
            side_reg[10] <= side_reg[9];
            vx10_reg     <= {1'b1, vn};
            sh10_reg     <= sh_next;
        end
        if (en[11])
        begin
            side_reg[11] <= side_reg[10];
            vr11_reg     <= vr_next;
            sh11_reg     <= sh10_reg;
        end
        if (en[12])
        begin
            posit_out_reg <= out_next;
        end
    end

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while pipeline has room");

    a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[STAGES - 1] && en[STAGES - 1]) |=> out_valid)
        else $error("item lost before output stage");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[11] |-> (sh11_reg >= 5'd12 && sh11_reg <= 5'd25))
        else $error("rounding shift out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[10] && !en[11]) |=> (vld_reg[11] && vld_reg[12]))
        else $error("stalled stage lost its item");

endmodule

// File: tb/posit16_cospi_checker.sv
`timescale 1ns / 1ps

module posit16_cospi_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] posit_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] posit_out,
    output int          mismatches,
    output int          outstanding
);
    import p16c_pkg::*;

    logic [15:0] cos_expected_q[$];
    int          fail_count = 0;
    int          waiting = 0;

    assign mismatches  = fail_count;
    assign outstanding = waiting;

    function automatic logic [15:0] cospi_expect(input logic [15:0] arg);
        logic [63:0] mag;
        logic [63:0] fx;
        logic [63:0] quad;
        logic [63:0] sq;
        logic [63:0] acc;
        logic [63:0] v;
        logic [63:0] rb;
        logic        neg_res;
        int          scale;
        int          norm;
        int          sh;
        int          i;
        if (arg == NAR_PATTERN)
            return NAR_PATTERN;
        mag = 64'(arg[15] ? (~arg + 16'd1) : arg);
        // decode regime and exponent into 28 fraction bits
        if (mag == 0)
            fx = 0;
        else
        begin
            if (mag[14])
            begin
                scale = 16;
                for (i = 0; i < 15 && mag[13]; i++)
                begin
                    mag = mag << 1;
                    scale += 2;
                end
            end
            else
            begin
                scale = 14;
                for (i = 0; i < 15 && !mag[13]; i++)
                begin
                    mag = mag << 1;
                    scale -= 2;
                end
            end
            if (mag[12])
                scale++;
            mag = (mag & 64'hFFF) | 64'h1000;
            fx = (scale < 0) ? (mag >> (-scale)) : (mag << scale);
        end
        quad = fx >> 27;
        fx = fx & 64'h7FFFFFF;
        neg_res = quad[1] ^ quad[0];
        if (fx == 0)
            return quad[0] ? POSIT_ZERO : (POSIT_ONE | {neg_res, 15'd0});
        if (quad[0])
            fx = 64'(HALF_VALUE) - fx;
        if (fx < 64'(TINY_LIMIT))
            v = 64'(ALMOST_ONE);
        else
        begin
            sq  = fx >> 11;
            sq  = (sq * sq) >> 8;
            acc = 64'(COEF_B) - ((sq * 64'(COEF_A)) >> 25);
            acc = 64'(COEF_C) - ((sq * acc) >> 24);
            acc = 64'(COEF_D) - ((sq * acc) >> 24);
            v   = 64'(COEF_E) - ((sq * acc) >> 23);
        end
        // normalize and round to nearest even
        norm = 1;
        for (i = 0; i < 25 && !v[24]; i++)
        begin
            v = v << 1;
            norm++;
        end
        if (norm % 2 == 0)
            v = v & 64'hFFFFFF;
        sh = norm / 2 + 12;
        if (norm % 2 == 0)
            sh--;
        v = v | 64'h2000000;
        rb = 64'd1 << (sh - 1);
        if ((v & rb) != 0 && ((v & (rb - 64'd1)) != 0 || (v & (rb << 1)) != 0))
            v = v + rb;
        v = v >> sh;
        return neg_res ? (~v[15:0] + 16'd1) : v[15:0];
    endfunction

    always @(posedge clk)
    begin
        logic [15:0] want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (cos_expected_q.size() == 0)
                begin
                    $display("%0t: posit_out expected none actual %h", $time, posit_out);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = cos_expected_q.pop_front();
                    if (want !== posit_out)
                    begin
                        $display("%0t: posit_out expected %h actual %h",
                                 $time, want, posit_out);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && !in_stall)
                cos_expected_q.push_back(cospi_expect(posit_in));
            waiting <= cos_expected_q.size();
        end
    end

endmodule

// File: tb/tb_posit16_cospi_fixed_point_core.sv
`timescale 1ns / 1ps

module tb_posit16_cospi_fixed_point_core;
    import p16c_pkg::*;

    localparam int RANDOM_ITEMS   = 1100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] posit_in = 16'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] posit_out;

    int   mismatches;
    int   outstanding;
    int   stuck_cycles = 0;
    int   taken = 0;
    logic send_relaxed = 1'b0;
    logic recv_relaxed = 1'b1;

    logic [15:0] corners [24] = '{
        16'h0000, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8001,
        16'h4000, 16'hC000, 16'h3000, 16'hD000, 16'h2000, 16'h3800,
        16'h4800, 16'h5000, 16'h5800, 16'h6000, 16'h7000, 16'h7F00,
        16'h3FFF, 16'h4001, 16'h2FFF, 16'h3001, 16'h0100, 16'h1000
    };

    posit16_cospi_fixed_point_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .posit_in  (posit_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .posit_out (posit_out)
    );

    posit16_cospi_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .posit_in    (posit_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .posit_out   (posit_out),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic offer_posit(input logic [15:0] arg);
        int gap;
        gap = send_relaxed ? $urandom_range(0, 14) : 0;
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        posit_in <= arg;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    initial
    begin
        logic [15:0] arg;
        int          sel;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (corners[k])
            offer_posit(corners[k]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 64 == 0)
                send_relaxed = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 9);
            if (sel < 5)
                arg = 16'($urandom);
            else if (sel < 8)
            begin
                arg = 16'($urandom_range(16'h0800, 16'h57FF));
                if ($urandom_range(0, 1))
                    arg = ~arg + 16'd1;
            end
            else
                arg = corners[$urandom_range(0, 23)] + 16'($urandom_range(0, 4)) - 16'd2;
            offer_posit(arg);
        end
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (2 * STAGES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int gap;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (taken == HOLD_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            gap = recv_relaxed ? $urandom_range(0, 14) : 0;
            repeat (gap)
            begin
                out_stall <= 1'b1;
                @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
            if (taken % 64 == 0)
                recv_relaxed = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

endmodule
